// ===== rtl/core/kmp_substring_search_macros.svh =====
// Assertion macros used by the substring search controller.
`ifndef KMP_SUBSTRING_SEARCH_MACROS_SVH
`define KMP_SUBSTRING_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
`define KSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KSS_ASSERT(lbl, clk, rst, prop, msg)
`define KSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/kmp_pkg.sv =====
// Shared constants, status codes and control types of the substring search block.
package kmp_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int PAT_AW      = $clog2(PATTERN_MAX);
   localparam int LEN_W       = PAT_AW + 1;
   localparam int TEXT_MAX    = 65536;
   localparam int TPOS_W      = $clog2(TEXT_MAX) + 1;
   localparam int CHAR_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 16;
   localparam int FAIL_W      = 6;
   localparam int CALC_W      = (TPOS_W > POS_W) ? TPOS_W : POS_W;

   localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SEARCH  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOPAT   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_AFTER   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd7;

   typedef struct packed {
      logic capture;
      logic setup;
      logic step;
      logic resolve;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_search;
      logic loop_more;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== rtl/core/kmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/kmp_ctrl.sv =====
// Controller state machine that sequences request setup, table walk and response.
`include "kmp_substring_search_macros.svh"

module kmp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kmp_pkg::stat_type stat,
   output kmp_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = stat.need_search ? S_READ : S_DONE;
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = stat.loop_more ? S_READ : S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.setup   = (state_ff == S_EVAL);
   assign cmd.step    = (state_ff == S_CMP) && stat.loop_more;
   assign cmd.resolve = (state_ff == S_CMP) && !stat.loop_more;
   assign cmd.commit  = (state_ff == S_DONE) && !stat.rsp_busy;

   `KSS_ASSERT_NEXT(a_capture_eval, clock, reset, cmd.capture, state_ff == S_EVAL, "request not set up")
   `KSS_ASSERT_NEXT(a_step_read, clock, reset, cmd.step, state_ff == S_READ, "fallback not reread")
   `KSS_ASSERT_NEXT(a_done_hold, clock, reset, (state_ff == S_DONE) && stat.rsp_busy, state_ff == S_DONE, "stalled response dropped")
   `KSS_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "conflicting datapath commands")

endmodule

// ===== rtl/core/kmp_dp.sv =====
// Datapath with pattern and failure memories, search state and response register.
module kmp_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_action,
   input  logic                          req_first,
   input  logic                          req_last,
   input  logic [kmp_pkg::CHAR_W-1:0]    req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kmp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kmp_pkg::POS_W-1:0]     rsp_position,
   output logic [kmp_pkg::FAIL_W-1:0]    rsp_fail_value,
   input  kmp_pkg::cmd_type              cmd,
   output kmp_pkg::stat_type             stat
);

   logic                          act_ff, first_ff, last_ff;
   logic [kmp_pkg::CHAR_W-1:0]    ch_ff;
   logic [kmp_pkg::LEN_W-1:0]     pat_len_ff, pat_len_in;
   logic [kmp_pkg::PAT_AW-1:0]    build_pfx_ff, build_pfx_in;
   logic [kmp_pkg::PAT_AW-1:0]    match_prog_ff, match_prog_in;
   logic [kmp_pkg::TPOS_W-1:0]    text_pos_ff, text_pos_in;
   logic                          found_ff, found_in;
   logic                          ovf_ff, ovf_in;
   logic [kmp_pkg::PAT_AW-1:0]    k_ff, k_in;
   logic [kmp_pkg::LEN_W-1:0]     j_ff, j_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kmp_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [kmp_pkg::POS_W-1:0]     rsp_position_ff, rsp_position_in;
   logic [kmp_pkg::FAIL_W-1:0]    rsp_fail_value_ff, rsp_fail_value_in;

   logic                          pat_first;
   logic [kmp_pkg::LEN_W-1:0]     eff_len;
   logic [kmp_pkg::PAT_AW-1:0]    eff_bp, eff_mp;
   logic [kmp_pkg::TPOS_W-1:0]    eff_tpos;
   logic                          eff_found, eff_ovf, eff_full;
   logic                          ram_we;
   logic [kmp_pkg::CHAR_W-1:0]    pat_rd;
   logic [kmp_pkg::PAT_AW-1:0]    fail_rd;
   logic                          hit;
   logic [kmp_pkg::CALC_W-1:0]    pos_calc;

   assign pat_first = !act_ff && first_ff;
   assign eff_len   = pat_first ? '0 : pat_len_ff;
   assign eff_bp    = pat_first ? '0 : build_pfx_ff;
   assign eff_mp    = first_ff ? '0 : match_prog_ff;
   assign eff_tpos  = first_ff ? '0 : text_pos_ff;
   assign eff_found = first_ff ? 1'b0 : found_ff;
   assign eff_ovf   = first_ff ? 1'b0 : ovf_ff;
   assign eff_full  = (eff_len >= kmp_pkg::LEN_W'(kmp_pkg::PATTERN_MAX));
   assign ram_we    = cmd.setup && !act_ff && !eff_full;

   assign hit = (pat_rd == ch_ff);

   assign stat.loop_more = !hit && (k_ff != '0);
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign stat.need_search = act_ff
      ? ((eff_len != '0) && !eff_found && !eff_ovf
         && (eff_tpos < kmp_pkg::TPOS_W'(kmp_pkg::TEXT_MAX)))
      : (!eff_full && (eff_len != '0));

   assign pos_calc = kmp_pkg::CALC_W'(text_pos_ff) + kmp_pkg::CALC_W'(1)
                     - kmp_pkg::CALC_W'(pat_len_ff);

   kmp_ram #(
      .WIDTH (kmp_pkg::CHAR_W),
      .DEPTH (kmp_pkg::PATTERN_MAX)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (eff_len[kmp_pkg::PAT_AW-1:0]),
      .wr_data (ch_ff),
      .rd_addr (k_ff),
      .rd_data (pat_rd)
   );

   kmp_ram #(
      .WIDTH (kmp_pkg::PAT_AW),
      .DEPTH (kmp_pkg::PATTERN_MAX)
   ) u_fail_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (eff_len[kmp_pkg::PAT_AW-1:0]),
      .wr_data (eff_bp),
      .rd_addr (k_ff),
      .rd_data (fail_rd)
   );

   always_comb begin
      pat_len_in        = pat_len_ff;
      build_pfx_in      = build_pfx_ff;
      match_prog_in     = match_prog_ff;
      text_pos_in       = text_pos_ff;
      found_in          = found_ff;
      ovf_in            = ovf_ff;
      k_in              = k_ff;
      j_in              = j_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_position_in   = rsp_position_ff;
      rsp_fail_value_in = rsp_fail_value_ff;
      rsp_valid_in      = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.setup) begin
         if (pat_first) begin
            pat_len_in   = '0;
            build_pfx_in = '0;
         end
         if (first_ff) begin
            match_prog_in = '0;
            text_pos_in   = '0;
            found_in      = 1'b0;
            ovf_in        = 1'b0;
         end
         k_in = act_ff ? eff_mp : eff_bp;
      end

      if (cmd.step) begin
         k_in = fail_rd;
      end

      if (cmd.resolve) begin
         j_in = hit ? (kmp_pkg::LEN_W'(k_ff) + kmp_pkg::LEN_W'(1)) : '0;
      end

      if (cmd.commit) begin
         rsp_valid_in      = 1'b1;
         rsp_position_in   = '0;
         rsp_fail_value_in = '0;
         if (!act_ff) begin
            if (pat_len_ff >= kmp_pkg::LEN_W'(kmp_pkg::PATTERN_MAX)) begin
               rsp_status_in = kmp_pkg::ST_FULL;
            end else begin
               rsp_status_in     = kmp_pkg::ST_STORED;
               rsp_fail_value_in = kmp_pkg::FAIL_W'(build_pfx_ff);
               build_pfx_in      = (pat_len_ff == '0) ? '0 : j_ff[kmp_pkg::PAT_AW-1:0];
               pat_len_in        = pat_len_ff + kmp_pkg::LEN_W'(1);
            end
         end else begin
            priority if (pat_len_ff == '0) begin
               rsp_status_in = kmp_pkg::ST_NOPAT;
            end else if (found_ff) begin
               rsp_status_in = kmp_pkg::ST_AFTER;
            end else if (ovf_ff
                         || (text_pos_ff >= kmp_pkg::TPOS_W'(kmp_pkg::TEXT_MAX))) begin
               ovf_in        = 1'b1;
               rsp_status_in = kmp_pkg::ST_OVER;
            end else begin
               text_pos_in = text_pos_ff + kmp_pkg::TPOS_W'(1);
               if (j_ff >= pat_len_ff) begin
                  found_in        = 1'b1;
                  match_prog_in   = '0;
                  rsp_position_in = pos_calc[kmp_pkg::POS_W-1:0];
                  rsp_status_in   = kmp_pkg::ST_MATCH;
               end else begin
                  match_prog_in = j_ff[kmp_pkg::PAT_AW-1:0];
                  rsp_status_in = last_ff ? kmp_pkg::ST_NOMATCH : kmp_pkg::ST_SEARCH;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff    <= '0;
         build_pfx_ff  <= '0;
         match_prog_ff <= '0;
         text_pos_ff   <= '0;
         found_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pat_len_ff    <= pat_len_in;
         build_pfx_ff  <= build_pfx_in;
         match_prog_ff <= match_prog_in;
         text_pos_ff   <= text_pos_in;
         found_ff      <= found_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         first_ff <= req_first;
         last_ff  <= req_last;
         ch_ff    <= req_ch;
      end
      k_ff              <= k_in;
      j_ff              <= j_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_fail_value_ff <= rsp_fail_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_fail_value = rsp_fail_value_ff;

endmodule

// ===== rtl/core/kmp_substring_search.sv =====
// Top level of the Knuth-Morris-Pratt substring search block.
//
//   Channel   Direction   Ports
//   req       in          req_valid, req_ready, req_action, req_first, req_last, req_ch
//   rsp       out         rsp_valid, rsp_ready, rsp_status, rsp_position, rsp_fail_value
//
// One request is in work at a time. A request that needs no table walk goes straight to
// its response. A stored pattern character after the first, or a searched text character,
// walks the failure table; each fallback is one registered read of both memories.
// Reset clears all control state; the pattern and failure memories need no clearing.
// A new request is taken while the previous response waits; a stalled response holds
// the following one in its final state until rsp_ready frees the output register.
module kmp_substring_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic                          req_first,
   input  logic                          req_last,
   input  logic [kmp_pkg::CHAR_W-1:0]    req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kmp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kmp_pkg::POS_W-1:0]     rsp_position,
   output logic [kmp_pkg::FAIL_W-1:0]    rsp_fail_value
);

   kmp_pkg::cmd_type  cmd;
   kmp_pkg::stat_type stat;

   kmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kmp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_first      (req_first),
      .req_last       (req_last),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fail_value (rsp_fail_value),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

// ===== tb/kmp_search_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the substring search block: predicts every response and compares it.
module kmp_search_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_action,
   input  logic                          req_first,
   input  logic                          req_last,
   input  logic [kmp_pkg::CHAR_W-1:0]    req_ch,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [kmp_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [kmp_pkg::POS_W-1:0]     rsp_position,
   input  logic [kmp_pkg::FAIL_W-1:0]    rsp_fail_value,
   output int                            fail_count,
   output int                            awaiting
);

   typedef struct packed {
      logic [kmp_pkg::STATUS_W-1:0] status;
      logic [kmp_pkg::POS_W-1:0]    position;
      logic [kmp_pkg::FAIL_W-1:0]   fail_value;
   } outcome_type;

   logic [kmp_pkg::CHAR_W-1:0] pat_mem  [kmp_pkg::PATTERN_MAX];
   logic [kmp_pkg::FAIL_W-1:0] fail_mem [kmp_pkg::PATTERN_MAX];
   int                         pat_len;
   int                         next_border;
   int                         match_len;
   int                         text_idx;
   bit                         matched;
   bit                         overrun;

   outcome_type                expected_q [$];
   int                         mismatches = 0;

   function automatic void clear_text_state();
      text_idx  = 0;
      match_len = 0;
      matched   = 1'b0;
      overrun   = 1'b0;
   endfunction

   function automatic int grow_border(int k, logic [kmp_pkg::CHAR_W-1:0] c);
      while (k > 0 && pat_mem[k] != c) begin
         k = fail_mem[k];
      end
      return (pat_mem[k] == c) ? k + 1 : 0;
   endfunction

   function automatic outcome_type search_outcome(logic text_item, logic first,
                                                  logic last_flag,
                                                  logic [kmp_pkg::CHAR_W-1:0] c);
      outcome_type r;
      int          idx;
      int          j;
      r = '0;
      if (!text_item) begin
         if (first) begin
            pat_len     = 0;
            next_border = 0;
            clear_text_state();
         end
         if (pat_len >= kmp_pkg::PATTERN_MAX) begin
            r.status = kmp_pkg::ST_FULL;
         end else begin
            r.status          = kmp_pkg::ST_STORED;
            r.fail_value      = kmp_pkg::FAIL_W'(next_border);
            pat_mem[pat_len]  = c;
            fail_mem[pat_len] = kmp_pkg::FAIL_W'(next_border);
            next_border       = (pat_len == 0) ? 0 : grow_border(next_border, c);
            pat_len++;
         end
      end else begin
         if (first) begin
            clear_text_state();
         end
         if (pat_len == 0) begin
            r.status = kmp_pkg::ST_NOPAT;
         end else if (matched) begin
            r.status = kmp_pkg::ST_AFTER;
         end else if (overrun || text_idx >= kmp_pkg::TEXT_MAX) begin
            overrun  = 1'b1;
            r.status = kmp_pkg::ST_OVER;
         end else begin
            idx      = text_idx;
            j        = grow_border(match_len, c);
            text_idx = idx + 1;
            if (j >= pat_len) begin
               matched    = 1'b1;
               match_len  = 0;
               r.position = kmp_pkg::POS_W'(idx + 1 - pat_len);
               r.status   = kmp_pkg::ST_MATCH;
            end else begin
               match_len = j;
               r.status  = last_flag ? kmp_pkg::ST_NOMATCH : kmp_pkg::ST_SEARCH;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         pat_len     = 0;
         next_border = 0;
         clear_text_state();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with status %0d arrived with no request waiting", rsp_status);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  mismatches++;
               end
               if (rsp_fail_value !== want.fail_value) begin
                  $error("fail_value: expected %0d, got %0d", want.fail_value, rsp_fail_value);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_q.push_back(search_outcome(req_action, req_first, req_last, req_ch));
         end
      end
      fail_count <= mismatches;
      awaiting   <= expected_q.size();
   end

endmodule

// ===== tb/tb_kmp_substring_search.sv =====
`timescale 1ns / 100ps
// Top of the substring search testbench: clock, reset, request stimulus and the verdict.
module tb_kmp_substring_search;

   localparam logic PATTERN_CHAR = 1'b0;
   localparam logic TEXT_CHAR    = 1'b1;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_action  = 1'b0;
   logic                           req_first   = 1'b0;
   logic                           req_last    = 1'b0;
   logic [kmp_pkg::CHAR_W-1:0]     req_ch      = '0;
   logic                           rsp_ready   = 1'b0;
   logic                           req_ready;
   logic                           rsp_valid;
   logic [kmp_pkg::STATUS_W-1:0]   rsp_status;
   logic [kmp_pkg::POS_W-1:0]      rsp_position;
   logic [kmp_pkg::FAIL_W-1:0]     rsp_fail_value;

   int                             fail_count;
   int                             awaiting;
   int                             sent_count    = 0;
   int                             send_idle_pct = 0;
   int                             stall_pct     = 0;
   logic                           hold_rsp      = 1'b0;

   kmp_substring_search DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_first      (req_first),
      .req_last       (req_last),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fail_value (rsp_fail_value)
   );

   kmp_search_checker u_search_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_first      (req_first),
      .req_last       (req_last),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_fail_value (rsp_fail_value),
      .fail_count     (fail_count),
      .awaiting       (awaiting)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
   end

   task automatic send_request(input logic text_item, input logic first, input logic last_flag,
                               input logic [kmp_pkg::CHAR_W-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= text_item;
      req_first  <= first;
      req_last   <= last_flag;
      req_ch     <= c;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   // A session usually loads a short pattern over a small alphabet and then searches a text
   // drawn mostly from the same alphabet, so that partial matches and fallbacks are frequent.
   task automatic random_session();
      logic [kmp_pkg::CHAR_W-1:0] alpha [3];
      logic [kmp_pkg::CHAR_W-1:0] c;
      int                         asize;
      int                         plen;
      int                         tlen;
      int                         k;
      asize = $urandom_range(3, 1);
      foreach (alpha[i]) begin
         alpha[i] = 8'($urandom);
      end
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(5, 1)) begin
            send_request(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
         end
         return;
      end
      if ($urandom_range(99) < 90) begin
         plen = ($urandom_range(99) < 90) ? $urandom_range(6, 1)
                                          : $urandom_range(kmp_pkg::PATTERN_MAX + 3, 7);
         for (k = 0; k < plen; k++) begin
            send_request(PATTERN_CHAR, (k == 0) && ($urandom_range(99) < 92), 1'($urandom),
                         alpha[$urandom_range(asize - 1)]);
         end
      end
      tlen = $urandom_range(40, 1);
      for (k = 0; k < tlen; k++) begin
         if ($urandom_range(99) < 2) begin
            send_request(PATTERN_CHAR, 1'b0, 1'($urandom), alpha[$urandom_range(asize - 1)]);
         end
         c = ($urandom_range(99) < 90) ? alpha[$urandom_range(asize - 1)] : 8'($urandom);
         send_request(TEXT_CHAR, (k == 0) && ($urandom_range(99) < 95),
                      (k == tlen - 1) ? 1'b1 : ($urandom_range(99) < 4), c);
      end
   endtask

   initial begin
      logic [kmp_pkg::CHAR_W-1:0] probe [10];
      int                         idx;
      int                         phase_end;

      probe = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(TEXT_CHAR, 1'b1, 1'b1, 8'h00);
      send_request(PATTERN_CHAR, 1'b1, 1'b1, 8'h00);
      send_request(PATTERN_CHAR, 1'b0, 1'b0, 8'hFF);
      send_request(PATTERN_CHAR, 1'b0, 1'b1, 8'h00);
      send_request(PATTERN_CHAR, 1'b0, 1'b0, 8'hFF);
      send_request(PATTERN_CHAR, 1'b0, 1'b0, 8'h00);
      for (idx = 0; idx < 10; idx++) begin
         send_request(TEXT_CHAR, idx == 0, idx == 4, probe[idx]);
      end
      send_request(TEXT_CHAR, 1'b0, 1'b1, 8'hFF);
      send_request(TEXT_CHAR, 1'b1, 1'b0, 8'h00);
      send_request(PATTERN_CHAR, 1'b0, 1'b0, 8'h7F);
      send_request(TEXT_CHAR, 1'b0, 1'b0, 8'hFF);
      send_request(TEXT_CHAR, 1'b0, 1'b1, 8'h80);

      // A pattern of one repeated character gives the deepest failure chain.
      for (idx = 0; idx <= kmp_pkg::PATTERN_MAX; idx++) begin
         send_request(PATTERN_CHAR, idx == 0, 1'b0, 8'h41);
      end
      for (idx = 0; idx < kmp_pkg::PATTERN_MAX - 1; idx++) begin
         send_request(TEXT_CHAR, idx == 0, 1'b0, 8'h41);
      end
      send_request(TEXT_CHAR, 1'b0, 1'b0, 8'h42);
      for (idx = 0; idx < kmp_pkg::PATTERN_MAX; idx++) begin
         send_request(TEXT_CHAR, 1'b0, idx == kmp_pkg::PATTERN_MAX - 1, 8'h41);
      end

      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            repeat (3) random_session();
         end
      join

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 79;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 79;
            end
            default: begin
               send_idle_pct = 17;
               stall_pct     = 17;
            end
         endcase
         phase_end = sent_count + 240;
         while (sent_count < phase_end) begin
            random_session();
         end
      end

      req_valid <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      while (awaiting != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("** kmp_substring_search: PASSED **");
      end else begin
         $display("** kmp_substring_search: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** kmp_substring_search: FAILED **");
      $finish;
   end

endmodule

// ===== kmp_substring_search.f =====
+incdir+rtl/core
rtl/core/kmp_pkg.sv
rtl/core/kmp_ram.sv
rtl/core/kmp_ctrl.sv
rtl/core/kmp_dp.sv
rtl/core/kmp_substring_search.sv
tb/kmp_search_checker.sv
tb/tb_kmp_substring_search.sv
